@@ src/sme_pkg.sv @@
// Shared types and constants for the SPI master byte engine.
// No dependencies; imported by every module of the block.
package sme_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SEND_HALF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_LEAD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_HALF = 2'd2;

    localparam logic [CFG_DATA_W-1:0] SEND_HALF_RST = 16'd100;
    localparam logic [CFG_DATA_W-1:0] READ_LEAD_RST = 16'd100;
    localparam logic [CFG_DATA_W-1:0] READ_HALF_RST = 16'd200;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam logic [2:0] BIT_MSB = 3'd7;

    // raw command codes on the input port
    localparam logic [1:0] CMD_CODE_SEND = 2'd1;
    localparam logic [1:0] CMD_CODE_READ = 2'd2;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_SEND = 2'd1,
        CMD_READ = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_S_SETUP = 3'd1,
        PH_S_HIGH  = 3'd2,
        PH_R_LEAD  = 3'd3,
        PH_R_HIGH  = 3'd4,
        PH_R_LOW   = 3'd5
    } t_phase;

    typedef struct packed {
        t_cmd       kind;
        logic [7:0] tx_byte;
        logic       miso_level;
    } t_item;

    typedef struct packed {
        logic       sck_level;
        logic       mosi_level;
        logic       nss_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
    } t_result;

endpackage

@@ src/spi_master_byte_engine.sv @@
// Top level of the SPI master byte engine (mode 0, pin level).
// Depends on sme_pkg, sme_front, sme_engine and sme_res_queue.
//
//  channel   | handshake        | payload
//  ----------+------------------+----------------------------------------------
//  tick in   | push / full      | i_command, i_tx_byte, i_miso_level
//  result    | empty / pop      | o_sck_level, o_mosi_level, o_nss_level,
//            |                  | o_busy_res, o_done_res, o_rx_byte
//  config    | i_cfg_we         | i_cfg_index, i_cfg_data
//
// One tick per clock sustained while results are popped; a pushed tick waits in
// the front queue until the engine takes it, and its result is then poppable.
// The rate is set by the sequencer in sme_engine, which steps once per taken tick.
// Two-entry queues on both sides of the engine let either side stall alone.
// Reset is synchronous: both queues empty, sequencer idle, registers at defaults.
module spi_master_byte_engine
    import sme_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [1:0]            i_command,
    input  logic [7:0]            i_tx_byte,
    input  logic                  i_miso_level,
    output logic                  empty,
    input  logic                  pop,
    output logic                  o_sck_level,
    output logic                  o_mosi_level,
    output logic                  o_nss_level,
    output logic                  o_busy_res,
    output logic                  o_done_res,
    output logic [7:0]            o_rx_byte,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic    w_item_valid;
    t_item   w_item;
    logic    w_res_full;
    logic    w_take;
    t_result w_eng_res;
    t_result w_out_res;

    // advance the engine only when a tick waits and the result has room
    assign w_take = w_item_valid && !w_res_full;

    sme_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_command    (i_command),
        .i_tx_byte    (i_tx_byte),
        .i_miso_level (i_miso_level),
        .i_take       (w_take),
        .o_valid      (w_item_valid),
        .o_item       (w_item)
    );

    sme_engine #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_take      (w_take),
        .i_item      (w_item),
        .o_res       (w_eng_res)
    );

    sme_res_queue u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_take),
        .i_res   (w_eng_res),
        .o_full  (w_res_full),
        .empty   (empty),
        .pop     (pop),
        .o_res   (w_out_res)
    );

    assign o_sck_level  = w_out_res.sck_level;
    assign o_mosi_level = w_out_res.mosi_level;
    assign o_nss_level  = w_out_res.nss_level;
    assign o_busy_res   = w_out_res.busy_res;
    assign o_done_res   = w_out_res.done_res;
    assign o_rx_byte    = w_out_res.rx_byte;

    a_done_ends_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_done_res) |-> (o_nss_level && !o_busy_res))
        else $error("done shown while transfer still active");

    a_sck_needs_nss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_sck_level) |-> !o_nss_level)
        else $error("SCK high with NSS deasserted");

    a_idle_pins_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_nss_level) |-> (!o_mosi_level && !o_sck_level))
        else $error("MOSI or SCK active while idle");

    a_take_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_item_valid && !w_res_full) |=> !empty)
        else $error("engine step lost its result");

endmodule

@@ src/sme_front.sv @@
// Front end: accepts ticks, classifies the command and holds them in a
// two-entry queue for the engine. Depends on sme_pkg.
module sme_front
    import sme_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_command,
    input  logic [7:0] i_tx_byte,
    input  logic       i_miso_level,
    input  logic       i_take,
    output logic       o_valid,
    output t_item      o_item
);

    t_item      r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    t_item      w_item;
    logic       w_wr;
    logic       w_rd;

    always_comb begin
        w_item.tx_byte    = i_tx_byte;
        w_item.miso_level = i_miso_level;
        unique case (i_command)
            CMD_CODE_SEND: w_item.kind = CMD_SEND;
            CMD_CODE_READ: w_item.kind = CMD_READ;
            default:       w_item.kind = CMD_TICK;
        endcase
    end

    assign full    = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_entry[r_rd_ptr];
    assign w_wr    = push && !full;
    assign w_rd    = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_entry[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_rd) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ src/sme_engine.sv @@
// Back end: the pin-level SPI sequencer, one tick per taken item, plus the
// configuration registers. Depends on sme_pkg.
module sme_engine
    import sme_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_take,
    input  t_item                 i_item,
    output t_result               o_res
);

    localparam int EXT_W = (COUNT_WIDTH > CFG_DATA_W) ? COUNT_WIDTH : CFG_DATA_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    logic [CFG_DATA_W-1:0]  r_send_half;
    logic [CFG_DATA_W-1:0]  r_read_lead;
    logic [CFG_DATA_W-1:0]  r_read_half;

    t_phase                 r_phase,      n_phase;
    logic [2:0]             r_bit_index,  n_bit_index;
    logic [COUNT_WIDTH-1:0] r_wait_count, n_wait_count;
    logic [7:0]             r_shift_out,  n_shift_out;
    logic [7:0]             r_shift_in,   n_shift_in;
    logic                   w_done;
    logic                   w_expired;
    logic [COUNT_WIDTH-1:0] w_wait_dec;
    logic [COUNT_WIDTH-1:0] w_send_wait;
    logic [COUNT_WIDTH-1:0] w_lead_wait;
    logic [COUNT_WIDTH-1:0] w_read_wait;

    // zero acts as one tick; saturate to what the counter holds
    function automatic logic [COUNT_WIDTH-1:0] f_clamp(input logic [CFG_DATA_W-1:0] v);
        logic [EXT_W-1:0]       ve;
        logic [COUNT_WIDTH-1:0] res;
        ve = EXT_W'(v);
        if (v == '0) begin
            res = CNT_ONE;
        end else if (ve > EXT_W'(CNT_MAX)) begin
            res = CNT_MAX;
        end else begin
            res = COUNT_WIDTH'(ve);
        end
        return res;
    endfunction

    assign w_send_wait = f_clamp(r_send_half);
    assign w_lead_wait = f_clamp(r_read_lead);
    assign w_read_wait = f_clamp(r_read_half);
    assign w_expired   = (r_wait_count <= CNT_ONE);
    assign w_wait_dec  = r_wait_count - CNT_ONE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_send_half <= SEND_HALF_RST;
            r_read_lead <= READ_LEAD_RST;
            r_read_half <= READ_HALF_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SEND_HALF: r_send_half <= i_cfg_data;
                CFG_READ_LEAD: r_read_lead <= i_cfg_data;
                CFG_READ_HALF: r_read_half <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_index  <= BIT_MSB;
            r_wait_count <= '0;
            r_shift_out  <= '0;
            r_shift_in   <= '0;
        end else if (i_take) begin
            r_phase      <= n_phase;
            r_bit_index  <= n_bit_index;
            r_wait_count <= n_wait_count;
            r_shift_out  <= n_shift_out;
            r_shift_in   <= n_shift_in;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_bit_index  = r_bit_index;
        n_wait_count = r_wait_count;
        n_shift_out  = r_shift_out;
        n_shift_in   = r_shift_in;
        w_done       = 1'b0;
        unique case (r_phase)
            PH_S_SETUP: begin
                if (w_expired) begin
                    n_phase      = PH_S_HIGH;
                    n_wait_count = w_send_wait;
                end else begin
                    n_wait_count = w_wait_dec;
                end
            end
            PH_S_HIGH: begin
                if (!w_expired) begin
                    n_wait_count = w_wait_dec;
                end else if (r_bit_index == '0) begin
                    n_phase      = PH_IDLE;
                    n_bit_index  = BIT_MSB;
                    n_wait_count = '0;
                    w_done       = 1'b1;
                end else begin
                    n_bit_index  = r_bit_index - 3'd1;
                    n_phase      = PH_S_SETUP;
                    n_wait_count = w_send_wait;
                end
            end
            PH_R_LEAD: begin
                if (w_expired) begin
                    n_phase      = PH_R_HIGH;
                    n_wait_count = w_read_wait;
                end else begin
                    n_wait_count = w_wait_dec;
                end
            end
            PH_R_HIGH: begin
                if (w_expired) begin
                    // sample MISO as SCK falls
                    if (i_item.miso_level) begin
                        n_shift_out[r_bit_index] = 1'b1;
                    end
                    n_phase      = PH_R_LOW;
                    n_wait_count = w_read_wait;
                end else begin
                    n_wait_count = w_wait_dec;
                end
            end
            PH_R_LOW: begin
                if (!w_expired) begin
                    n_wait_count = w_wait_dec;
                end else if (r_bit_index == '0) begin
                    n_shift_in   = r_shift_out;
                    n_phase      = PH_IDLE;
                    n_bit_index  = BIT_MSB;
                    n_wait_count = '0;
                    w_done       = 1'b1;
                end else begin
                    n_bit_index  = r_bit_index - 3'd1;
                    n_phase      = PH_R_HIGH;
                    n_wait_count = w_read_wait;
                end
            end
            default: begin
                // idle, and unused codes fall back to idle
                n_phase = PH_IDLE;
                case (i_item.kind)
                    CMD_SEND: begin
                        n_bit_index  = BIT_MSB;
                        n_shift_out  = i_item.tx_byte;
                        n_phase      = PH_S_SETUP;
                        n_wait_count = w_send_wait;
                    end
                    CMD_READ: begin
                        n_bit_index = BIT_MSB;
                        n_shift_out = '0;
                        if (r_read_lead == '0) begin
                            n_phase      = PH_R_HIGH;
                            n_wait_count = w_read_wait;
                        end else begin
                            n_phase      = PH_R_LEAD;
                            n_wait_count = w_lead_wait;
                        end
                    end
                    default: ;
                endcase
            end
        endcase
    end

    always_comb begin
        o_res.sck_level  = (n_phase == PH_S_HIGH) || (n_phase == PH_R_HIGH);
        o_res.mosi_level = ((n_phase == PH_S_SETUP) || (n_phase == PH_S_HIGH))
                           && n_shift_out[n_bit_index];
        o_res.nss_level  = (n_phase == PH_IDLE);
        o_res.busy_res   = (n_phase != PH_IDLE);
        o_res.done_res   = w_done;
        o_res.rx_byte    = n_shift_in;
    end

endmodule

@@ src/sme_res_queue.sv @@
// Two-entry result queue between the engine and the result ports.
// Depends on sme_pkg.
module sme_res_queue
    import sme_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_full,
    output logic    empty,
    input  logic    pop,
    output t_result o_res
);

    t_result    r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_wr;
    logic       w_rd;

    assign o_full = (r_count == 2'd2);
    assign empty  = (r_count == 2'd0);
    assign o_res  = r_entry[r_rd_ptr];
    assign w_wr   = i_push && !o_full;
    assign w_rd   = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_entry[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_rd) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ tb/sme_checker.sv @@
// Checker for the SPI master byte engine: watches the tick, result and register channels.
// Predicts each result beat from its own copy of the sequencer and compares it field by field.
// Depends on sme_pkg only.
module sme_checker
    import sme_pkg::*;
#(
    parameter int COUNT_W = COUNT_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    input  logic                  full,
    input  logic [1:0]            i_command,
    input  logic [7:0]            i_tx_byte,
    input  logic                  i_miso_level,
    input  logic                  empty,
    input  logic                  pop,
    input  logic                  i_sck_level,
    input  logic                  i_mosi_level,
    input  logic                  i_nss_level,
    input  logic                  i_busy_res,
    input  logic                  i_done_res,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_transfers
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    // timing registers as the engine sees them
    logic [CFG_DATA_W-1:0] send_half;
    logic [CFG_DATA_W-1:0] read_lead;
    logic [CFG_DATA_W-1:0] read_half;

    // sequencer copy
    t_phase             seq_phase;
    logic [2:0]         seq_bit;
    logic [COUNT_W-1:0] seq_wait;
    logic [7:0]         seq_shift;
    logic [7:0]         last_rx;

    t_result pin_levels_q[$];
    int      fail_cnt;
    int      pending_cnt;
    int      done_cnt;

    assign o_fail_count = fail_cnt;
    assign o_pending    = pending_cnt;
    assign o_transfers  = done_cnt;

    function automatic logic [COUNT_W-1:0] clamp_wait(input logic [CFG_DATA_W-1:0] v);
        longint unsigned cmax;
        cmax = (64'd1 << COUNT_W) - 64'd1;
        if (v == '0)
            return COUNT_W'(1);
        if (64'(v) > cmax)
            return COUNT_W'(cmax);
        return COUNT_W'(v);
    endfunction

    // count down; true once the current level has been held long enough
    function automatic logic wait_over();
        if (seq_wait > COUNT_W'(1)) begin
            seq_wait = seq_wait - COUNT_W'(1);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_result step_pins(input logic [1:0] cmd, input logic [7:0] tx,
                                          input logic miso);
        t_result r;
        logic    done;
        done = 1'b0;
        case (seq_phase)
            PH_S_SETUP: begin
                if (wait_over()) begin
                    seq_phase = PH_S_HIGH;
                    seq_wait  = clamp_wait(send_half);
                end
            end
            PH_S_HIGH: begin
                if (wait_over()) begin
                    if (seq_bit == 3'd0) begin
                        seq_phase = PH_IDLE;
                        seq_bit   = BIT_MSB;
                        seq_wait  = '0;
                        done      = 1'b1;
                    end else begin
                        seq_bit   = seq_bit - 3'd1;
                        seq_phase = PH_S_SETUP;
                        seq_wait  = clamp_wait(send_half);
                    end
                end
            end
            PH_R_LEAD: begin
                if (wait_over()) begin
                    seq_phase = PH_R_HIGH;
                    seq_wait  = clamp_wait(read_half);
                end
            end
            PH_R_HIGH: begin
                if (wait_over()) begin
                    if (miso)
                        seq_shift[seq_bit] = 1'b1;
                    seq_phase = PH_R_LOW;
                    seq_wait  = clamp_wait(read_half);
                end
            end
            PH_R_LOW: begin
                if (wait_over()) begin
                    if (seq_bit == 3'd0) begin
                        last_rx   = seq_shift;
                        seq_phase = PH_IDLE;
                        seq_bit   = BIT_MSB;
                        seq_wait  = '0;
                        done      = 1'b1;
                    end else begin
                        seq_bit   = seq_bit - 3'd1;
                        seq_phase = PH_R_HIGH;
                        seq_wait  = clamp_wait(read_half);
                    end
                end
            end
            default: begin
                // idle, and any stray phase code, takes a command
                seq_phase = PH_IDLE;
                if (cmd == CMD_SEND) begin
                    seq_bit   = BIT_MSB;
                    seq_shift = tx;
                    seq_phase = PH_S_SETUP;
                    seq_wait  = clamp_wait(send_half);
                end else if (cmd == CMD_READ) begin
                    seq_bit   = BIT_MSB;
                    seq_shift = '0;
                    if (read_lead == '0) begin
                        seq_phase = PH_R_HIGH;
                        seq_wait  = clamp_wait(read_half);
                    end else begin
                        seq_phase = PH_R_LEAD;
                        seq_wait  = clamp_wait(read_lead);
                    end
                end
            end
        endcase
        r.sck_level  = (seq_phase == PH_S_HIGH) || (seq_phase == PH_R_HIGH);
        r.mosi_level = ((seq_phase == PH_S_SETUP) || (seq_phase == PH_S_HIGH)) ?
                       seq_shift[seq_bit] : 1'b0;
        r.nss_level  = (seq_phase == PH_IDLE);
        r.busy_res   = (seq_phase != PH_IDLE);
        r.done_res   = done;
        r.rx_byte    = last_rx;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            send_half   = SEND_HALF_RST;
            read_lead   = READ_LEAD_RST;
            read_half   = READ_HALF_RST;
            seq_phase   = PH_IDLE;
            seq_bit     = BIT_MSB;
            seq_wait    = '0;
            seq_shift   = '0;
            last_rx     = '0;
            pin_levels_q.delete();
            fail_cnt    = 0;
            done_cnt    = 0;
        end else begin
            // a register written at this edge already governs the tick pushed at it
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SEND_HALF: send_half = i_cfg_data;
                    CFG_READ_LEAD: read_lead = i_cfg_data;
                    CFG_READ_HALF: read_half = i_cfg_data;
                    default: ;
                endcase
            end
            if (push && !full) begin
                want = step_pins(i_command, i_tx_byte, i_miso_level);
                if (want.done_res)
                    done_cnt++;
                pin_levels_q.push_back(want);
            end
            if (pop && !empty) begin
                got.sck_level  = i_sck_level;
                got.mosi_level = i_mosi_level;
                got.nss_level  = i_nss_level;
                got.busy_res   = i_busy_res;
                got.done_res   = i_done_res;
                got.rx_byte    = i_rx_byte;
                if (pin_levels_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS)
                        $display("[%0t] result beat with no tick waiting: rx=%02h", $realtime,
                                 got.rx_byte);
                end else begin
                    want = pin_levels_q.pop_front();
                    if (got.sck_level !== want.sck_level || got.mosi_level !== want.mosi_level ||
                        got.nss_level !== want.nss_level || got.busy_res !== want.busy_res ||
                        got.done_res !== want.done_res || got.rx_byte !== want.rx_byte) begin
                        fail_cnt++;
                        if (fail_cnt <= MAX_REPORTS)
                            $display({"[%0t] mismatch: expected sck=%b mosi=%b nss=%b busy=%b ",
                                      "done=%b rx=%02h, got sck=%b mosi=%b nss=%b busy=%b ",
                                      "done=%b rx=%02h"}, $realtime,
                                     want.sck_level, want.mosi_level, want.nss_level,
                                     want.busy_res, want.done_res, want.rx_byte,
                                     got.sck_level, got.mosi_level, got.nss_level,
                                     got.busy_res, got.done_res, got.rx_byte);
                    end
                end
            end
        end
        pending_cnt = pin_levels_q.size();
    end

endmodule

@@ tb/testbench.sv @@
// Top of the SPI master byte engine testbench: clock, reset, tick and result traffic, verdict.
// Instantiates spi_master_byte_engine and sme_checker; depends on sme_pkg.
module testbench;
    import sme_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]           CMD_SPARE      = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE  = 2'd3;
    localparam int                   HOLD_CYCLES    = 60;
    localparam int                   WATCHDOG_LIMIT = 2000;
    localparam int                   TAIL_CYCLES    = 20;
    localparam int                   RANDOM_PHASES  = 3;
    localparam int                   PHASE_BEATS    = 240;
    localparam int                   FULL_SCALE     = 65535;
    localparam int                   DEFAULT_SPAN   = 110;
    localparam int                   SEND_SETTLE    = 120;
    localparam int                   READ_SETTLE    = 220;

    // receiver patterns
    localparam int RX_FREE  = 0;
    localparam int RX_3OF4  = 1;
    localparam int RX_COIN  = 2;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  push         = 1'b0;
    logic [1:0]            i_command    = CMD_TICK;
    logic [7:0]            i_tx_byte    = 8'h00;
    logic                  i_miso_level = 1'b0;
    logic                  pop          = 1'b0;
    logic                  i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index  = CFG_SEND_HALF;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                  full;
    logic                  empty;
    logic                  o_sck_level;
    logic                  o_mosi_level;
    logic                  o_nss_level;
    logic                  o_busy_res;
    logic                  o_done_res;
    logic [7:0]            o_rx_byte;

    int fail_count;
    int pending;
    int transfers;
    int squeeze_req  = 0;
    int burst_left   = 0;
    bit steady       = 1'b0;
    int ticks_sent   = 0;
    int random_ticks = 0;
    int settings     = 0;
    int quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    spi_master_byte_engine i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_command    (i_command),
        .i_tx_byte    (i_tx_byte),
        .i_miso_level (i_miso_level),
        .empty        (empty),
        .pop          (pop),
        .o_sck_level  (o_sck_level),
        .o_mosi_level (o_mosi_level),
        .o_nss_level  (o_nss_level),
        .o_busy_res   (o_busy_res),
        .o_done_res   (o_done_res),
        .o_rx_byte    (o_rx_byte),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    sme_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_command    (i_command),
        .i_tx_byte    (i_tx_byte),
        .i_miso_level (i_miso_level),
        .empty        (empty),
        .pop          (pop),
        .i_sck_level  (o_sck_level),
        .i_mosi_level (o_mosi_level),
        .i_nss_level  (o_nss_level),
        .i_busy_res   (o_busy_res),
        .i_done_res   (o_done_res),
        .i_rx_byte    (o_rx_byte),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_transfers  (transfers)
    );

    // receiver: own pop pattern, plus a long hold-off whenever the sender asks for one
    initial begin
        int mode;
        int mode_left;
        int hold_left;
        int served;
        int step;
        mode      = RX_FREE;
        mode_left = 0;
        hold_left = 0;
        served    = 0;
        step      = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (squeeze_req != served) begin
                served++;
                hold_left = HOLD_CYCLES - 1;
                pop <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(RX_COIN, RX_FREE);
                    mode_left = $urandom_range(300, 40);
                end
                mode_left--;
                step++;
                case (mode)
                    RX_FREE: pop <= 1'b1;
                    RX_3OF4: pop <= (step % 4) != 3;
                    default: pop <= 1'($urandom_range(1, 0));
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
                $display("testbench failed");
                $finish;
            end
        end
    end

    // offer one tick beat, in bursts with random gaps unless steady
    task automatic push_beat(input logic [1:0] cmd, input logic [7:0] tx, input logic miso);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(40, 1);
            gap = steady ? 0 : $urandom_range(6, 0);
            if (gap > 0) begin
                @(negedge i_clk);
                push <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        push         <= 1'b1;
        i_command    <= cmd;
        i_tx_byte    <= tx;
        i_miso_level <= miso;
        do @(posedge i_clk); while (full);
        ticks_sent++;
    endtask

    task automatic run_ticks(input int n);
        repeat (n) push_beat(CMD_TICK, 8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
    endtask

    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // drain, then load all timing registers (and poke the spare index)
    task automatic load_timing(input logic [CFG_DATA_W-1:0] sh, input logic [CFG_DATA_W-1:0] lead,
                               input logic [CFG_DATA_W-1:0] rh);
        drain();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_IDX_SPARE;
        i_cfg_data  <= CFG_DATA_W'($urandom_range(FULL_SCALE, 0));
        @(negedge i_clk);
        i_cfg_index <= CFG_SEND_HALF;
        i_cfg_data  <= sh;
        @(negedge i_clk);
        i_cfg_index <= CFG_READ_LEAD;
        i_cfg_data  <= lead;
        @(negedge i_clk);
        i_cfg_index <= CFG_READ_HALF;
        i_cfg_data  <= rh;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    // mostly idle ticks, with sends and reads often enough to keep the engine busy
    function automatic logic [1:0] pick_cmd();
        int r;
        r = $urandom_range(99, 0);
        if (r < 58)
            return CMD_TICK;
        if (r < 76)
            return CMD_SEND;
        if (r < 94)
            return CMD_READ;
        return CMD_SPARE;
    endfunction

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset timing: run past the first default phase, then shorten the rest of the byte
        push_beat(CMD_SEND, 8'h5A, 1'b0);
        run_ticks(DEFAULT_SPAN);
        load_timing(16'd1, 16'd0, 16'd1);
        run_ticks(SEND_SETTLE);

        load_timing(SEND_HALF_RST, READ_LEAD_RST, READ_HALF_RST);
        push_beat(CMD_READ, 8'h00, 1'b1);
        run_ticks(DEFAULT_SPAN);
        load_timing(16'd1, 16'd0, 16'd1);
        run_ticks(READ_SETTLE);

        // directed: zero half period, zero lead, spare code, commands while busy
        load_timing(16'd0, 16'd0, 16'd1);
        push_beat(CMD_SPARE, 8'hFF, 1'b1);
        push_beat(CMD_TICK, 8'h00, 1'b0);
        push_beat(CMD_SEND, 8'hFF, 1'b0);
        push_beat(CMD_READ, 8'h00, 1'b1);
        push_beat(CMD_SEND, 8'h00, 1'b1);
        run_ticks(14);
        push_beat(CMD_READ, 8'hFF, 1'b1);
        repeat (17) push_beat(CMD_TICK, 8'h00, 1'b1);

        // random traffic over several small timing settings
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 0)
                load_timing(16'd0, 16'd0, 16'd0);
            else
                load_timing(CFG_DATA_W'($urandom_range(4, 0)), CFG_DATA_W'($urandom_range(6, 0)),
                            CFG_DATA_W'($urandom_range(4, 0)));
            steady = (p % 2) == 1;
            // hold the receiver off while the sender keeps pushing, so both queues fill
            if (steady)
                squeeze_req <= squeeze_req + 1;
            repeat (PHASE_BEATS) begin
                push_beat(pick_cmd(), 8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
                random_ticks++;
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("ran %0d ticks (%0d random) over %0d timing settings, %0d transfers done",
                 ticks_sent, random_ticks, settings, transfers);
        $display("covered default and zero periods, mid-byte timing change, busy commands, %s%0d",
                 "spare code, hold-off cycles ", HOLD_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
